/* sv/frbgs_pkg.sv */
// ----------------------------------------------------------------------------
// Fragment reorder buffer package
// Shared types and constants for the fragment reorder buffer.
// ----------------------------------------------------------------------------
package frbgs_pkg;

  localparam int unsigned SeqW = 64;
  localparam int unsigned CntW = 64;
  localparam int unsigned LenW = 4;

  typedef enum logic [1:0] {
    ST_ACCEPTED = 2'd0,
    ST_LATE     = 2'd1,
    ST_CLOSED   = 2'd2,
    ST_CLEARED  = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LOOKUP,
    S_STORE,
    S_SRCH,
    S_SRCH_WAIT,
    S_EMIT,
    S_CHECK,
    S_OLD,
    S_OLD_WAIT,
    S_SKIP,
    S_STATUS
  } fsm_e;

  localparam logic [0:0] RegWindow = 1'b0;
  localparam logic [0:0] RegAccept = 1'b1;

endpackage

/* sv/fragment_reorder_buffer_gap_skip_top.sv */
// ----------------------------------------------------------------------------
// Fragment reorder buffer with gap skipping
// Stores sequenced fragments in a slot memory and releases them in order.
// ----------------------------------------------------------------------------
// An item takes a variable number of cycles. A push scans the slot memory
// once to look up its sequence and once to search for the expected sequence.
// Every released fragment adds another search, plus a read of the fragment
// through S_EMIT and S_SRCH_WAIT. Every conceded gap adds a scan for the
// oldest held fragment and one more search. The single read port of the
// slot memory makes these scans run one after another. A released fragment
// stays hidden in the output register until the next search shows whether
// another fragment follows, because that decides its last flag. A clear,
// closed or late item passes through S_STATUS, which loads its result into
// the output register. The next input is taken once the last result of the
// current one has left that register.
module fragment_reorder_buffer_gap_skip_top
  import frbgs_pkg::*;
#(
  parameter int unsigned MAX_WINDOW    = 15,
  parameter int unsigned PAYLOAD_BYTES = 8
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [2:0]                 paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic                       kind_i,
  input  logic [SeqW-1:0]            seq_i,
  input  logic [8*PAYLOAD_BYTES-1:0] payload_i,
  input  logic [LenW-1:0]            payload_len_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic                       fragment_valid_o,
  output logic [SeqW-1:0]            out_seq_o,
  output logic [8*PAYLOAD_BYTES-1:0] out_payload_o,
  output logic [LenW-1:0]            out_len_o,
  output logic                       after_gap_o,
  output logic [1:0]                 status_o,
  output logic [CntW-1:0]            fragments_total_o,
  output logic [CntW-1:0]            gaps_total_o,
  output logic [CntW-1:0]            bytes_total_o,
  output logic                       last_o
);

  localparam int unsigned NSlots = MAX_WINDOW + 1;
  localparam int unsigned IdxW   = $clog2(NSlots);
  localparam int unsigned PayW   = 8 * PAYLOAD_BYTES;
  localparam int unsigned HeldW  = $clog2(NSlots + 1);
  localparam logic [LenW-1:0] MaxLen = LenW'(PAYLOAD_BYTES);
  localparam logic [IdxW:0] LastIdx = (IdxW+1)'(NSlots - 1);

  typedef struct packed {
    logic [SeqW-1:0] seq;
    logic [PayW-1:0] pay;
    logic [LenW-1:0] len;
  } slot_t;

  // Configuration.
  logic [3:0] window_q;
  logic       accept_q;
  logic       wr_en;
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q <= 4'd15;
      accept_q <= 1'b1;
    end else if (wr_en && paddr[1:0] == 2'b00) begin
      if (paddr[2] == RegWindow) window_q <= pwdata[3:0];
      else                       accept_q <= pwdata[0];
    end
  end
  always_comb begin
    prdata = '0;
    if (paddr[2] == RegWindow) prdata[3:0] = window_q;
    else                       prdata[0]   = accept_q;
  end

  logic [HeldW-1:0] win_eff;
  assign win_eff = (32'(window_q) > MAX_WINDOW) ? HeldW'(MAX_WINDOW) : HeldW'(window_q);

  // Slot memory, one read port with registered read data.
  slot_t            mem [NSlots];
  logic             mem_we;
  logic [IdxW-1:0]  mem_wa;
  slot_t            mem_wd;
  logic [IdxW-1:0]  mem_ra;
  slot_t            mem_rd;
  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    mem_rd <= mem[mem_ra];
  end

  // Control and state registers.
  fsm_e             state_q, state_d;
  logic [NSlots-1:0] vld_q, vld_d;
  logic [SeqW-1:0]  exp_q, exp_d;
  logic             started_q, started_d;
  logic [CntW-1:0]  frag_q, frag_d, gap_q, gap_d, byte_q, byte_d;
  logic [IdxW:0]    ptr_q, ptr_d;       // scan pointer, one wider to hold the count
  logic [IdxW-1:0]  rptr_q, rptr_d;     // index of entry whose read is in flight
  logic             rv_q, rv_d;         // read data valid
  logic             hit_q, hit_d;
  logic [IdxW-1:0]  hidx_q, hidx_d;
  logic             gapf_q, gapf_d;
  logic             any_q, any_d;       // something was released
  logic [SeqW-1:0]  old_q, old_d;
  logic             have_q, have_d;
  logic [1:0]       st_q, st_d;
  slot_t            in_q, in_d;

  // Output register.
  logic             ov_q, ov_d;
  logic             dec_q, dec_d;       // last flag of the held result is known
  logic             ofv_q, ofv_d, ogap_q, ogap_d, olast_q, olast_d;
  slot_t            o_q, o_d;
  logic [1:0]       ost_q, ost_d;
  logic [CntW-1:0]  ofr_q, ofr_d, ogp_q, ogp_d, oby_q, oby_d;

  logic             out_take;
  logic             out_free;
  logic [HeldW-1:0] held;
  logic [IdxW-1:0]  free_idx;
  logic [LenW-1:0]  len_c;
  logic [PayW-1:0]  pay_mask;

  assign out_take = ov_q && dec_q && out_ready_i;
  assign out_free = !ov_q || out_take;

  always_comb begin
    held = '0;
    for (int i = 0; i < NSlots; i++) held = held + HeldW'(vld_q[i]);
    free_idx = '0;
    for (int i = NSlots - 1; i >= 0; i--) if (!vld_q[i]) free_idx = IdxW'(i);
  end

  always_comb begin
    len_c = (payload_len_i > MaxLen) ? MaxLen : payload_len_i;
    for (int b = 0; b < PAYLOAD_BYTES; b++)
      pay_mask[8*b +: 8] = (LenW'(b) < len_c) ? 8'hff : 8'h00;
  end

  assign in_ready_o = (state_q == S_IDLE) && !ov_q;

  always_comb begin
    state_d = state_q; vld_d = vld_q; exp_d = exp_q; started_d = started_q;
    frag_d = frag_q; gap_d = gap_q; byte_d = byte_q; ptr_d = ptr_q;
    rptr_d = rptr_q; rv_d = 1'b0; hit_d = hit_q; hidx_d = hidx_q;
    gapf_d = gapf_q; any_d = any_q; old_d = old_q; have_d = have_q;
    st_d = st_q; in_d = in_q;
    ov_d = ov_q && !out_take; dec_d = dec_q; ofv_d = ofv_q; ogap_d = ogap_q;
    olast_d = olast_q;
    o_d = o_q; ost_d = ost_q; ofr_d = ofr_q; ogp_d = ogp_q; oby_d = oby_q;
    mem_we = 1'b0; mem_wa = hidx_q; mem_wd = in_q; mem_ra = ptr_q[IdxW-1:0];

    case (state_q)
      S_IDLE: begin
        if (in_valid_i && in_ready_o) begin
          if (kind_i) begin
            vld_d = '0; exp_d = '0; started_d = 1'b0;
            frag_d = '0; gap_d = '0; byte_d = '0;
            st_d = ST_CLEARED; state_d = S_STATUS;
          end else if (!accept_q) begin
            st_d = ST_CLOSED; state_d = S_STATUS;
          end else if (started_q && seq_i < exp_q) begin
            st_d = ST_LATE; state_d = S_STATUS;
          end else begin
            if (!started_q) begin
              started_d = 1'b1; exp_d = seq_i;
            end
            in_d.seq = seq_i; in_d.pay = payload_i & pay_mask; in_d.len = len_c;
            st_d = ST_ACCEPTED; ptr_d = '0; hit_d = 1'b0;
            gapf_d = 1'b0; any_d = 1'b0; state_d = S_LOOKUP;
          end
        end
      end
      // Scan for a duplicate of the incoming sequence.
      S_LOOKUP: begin
        if (ptr_q <= LastIdx) begin
          mem_ra = ptr_q[IdxW-1:0]; rptr_d = ptr_q[IdxW-1:0]; rv_d = 1'b1;
          ptr_d = ptr_q + 1'b1;
        end else if (!rv_q) begin
          state_d = S_STORE;
        end
        if (rv_q && vld_q[rptr_q] && mem_rd.seq == in_q.seq && !hit_q) begin
          hit_d = 1'b1; hidx_d = rptr_q;
        end
      end
      S_STORE: begin
        mem_we = 1'b1; mem_wa = hit_q ? hidx_q : free_idx; mem_wd = in_q;
        vld_d[mem_wa] = 1'b1; frag_d = frag_q + 1'b1;
        ptr_d = '0; hit_d = 1'b0; state_d = S_SRCH;
      end
      // Scan for the expected sequence.
      S_SRCH: begin
        if (ptr_q <= LastIdx) begin
          mem_ra = ptr_q[IdxW-1:0]; rptr_d = ptr_q[IdxW-1:0]; rv_d = 1'b1;
          ptr_d = ptr_q + 1'b1;
        end else if (!rv_q) begin
          state_d = hit_q ? S_EMIT : S_CHECK;
        end
        if (rv_q && vld_q[rptr_q] && mem_rd.seq == exp_q && !hit_q) begin
          hit_d = 1'b1; hidx_d = rptr_q;
        end
      end
      S_EMIT: begin
        mem_ra = hidx_q;
        state_d = S_SRCH_WAIT;
      end
      S_SRCH_WAIT: begin
        mem_ra = hidx_q;
        if (ov_q && !dec_q) begin
          // Another fragment follows, so the held one is not the last.
          dec_d = 1'b1;
        end else if (out_free) begin
          ov_d = 1'b1; dec_d = 1'b0; ofv_d = 1'b1; o_d = mem_rd; ogap_d = gapf_q;
          ost_d = ST_ACCEPTED; olast_d = 1'b0;
          byte_d = byte_q + CntW'(mem_rd.len);
          ofr_d = frag_q; ogp_d = gap_q; oby_d = byte_q + CntW'(mem_rd.len);
          vld_d[hidx_q] = 1'b0; gapf_d = 1'b0; any_d = 1'b1;
          exp_d = exp_q + 1'b1;
          ptr_d = '0; hit_d = 1'b0; state_d = S_SRCH;
        end
      end
      S_CHECK: begin
        if (held > win_eff) begin
          ptr_d = '0; have_d = 1'b0; state_d = S_OLD;
        end else state_d = S_STATUS;
      end
      // Find the oldest held sequence.
      S_OLD: begin
        if (ptr_q <= LastIdx) begin
          mem_ra = ptr_q[IdxW-1:0]; rptr_d = ptr_q[IdxW-1:0]; rv_d = 1'b1;
          ptr_d = ptr_q + 1'b1;
        end else if (!rv_q) begin
          state_d = S_SKIP;
        end
        if (rv_q && vld_q[rptr_q] && (!have_q || mem_rd.seq < old_q)) begin
          have_d = 1'b1; old_d = mem_rd.seq;
        end
      end
      S_SKIP: begin
        gap_d = gap_q + ((old_q > exp_q) ? (old_q - exp_q) : CntW'(1));
        exp_d = old_q; gapf_d = 1'b1;
        ptr_d = '0; hit_d = 1'b0; state_d = S_SRCH;
      end
      S_STATUS: begin
        if (any_q && st_q == ST_ACCEPTED) begin
          // The last released fragment is still hidden in the output register.
          olast_d = 1'b1; dec_d = 1'b1;
          state_d = S_IDLE;
        end else if (out_free) begin
          ov_d = 1'b1; dec_d = 1'b1; ofv_d = 1'b0; o_d = '0; ogap_d = 1'b0;
          ost_d = st_q; olast_d = 1'b1;
          ofr_d = frag_d; ogp_d = gap_d; oby_d = byte_d;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; vld_q <= '0; exp_q <= '0; started_q <= 1'b0;
      frag_q <= '0; gap_q <= '0; byte_q <= '0; ptr_q <= '0; rv_q <= 1'b0;
      hit_q <= 1'b0; gapf_q <= 1'b0; any_q <= 1'b0; have_q <= 1'b0;
      ov_q <= 1'b0; dec_q <= 1'b0; st_q <= ST_ACCEPTED;
    end else begin
      state_q <= state_d; vld_q <= vld_d; exp_q <= exp_d; started_q <= started_d;
      frag_q <= frag_d; gap_q <= gap_d; byte_q <= byte_d; ptr_q <= ptr_d;
      rv_q <= rv_d; hit_q <= hit_d; gapf_q <= gapf_d; any_q <= any_d;
      have_q <= have_d; ov_q <= ov_d; dec_q <= dec_d; st_q <= st_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rptr_q <= rptr_d; hidx_q <= hidx_d; old_q <= old_d; in_q <= in_d;
    ofv_q <= ofv_d; ogap_q <= ogap_d; olast_q <= olast_d; o_q <= o_d;
    ost_q <= ost_d; ofr_q <= ofr_d; ogp_q <= ogp_d; oby_q <= oby_d;
  end

  assign out_valid_o       = ov_q && dec_q;
  assign fragment_valid_o  = ofv_q;
  assign out_seq_o         = o_q.seq;
  assign out_payload_o     = o_q.pay;
  assign out_len_o         = o_q.len;
  assign after_gap_o       = ogap_q;
  assign status_o          = ost_q;
  assign fragments_total_o = ofr_q;
  assign gaps_total_o      = ogp_q;
  assign bytes_total_o     = oby_q;
  assign last_o            = olast_q;

  // A released fragment's result stays hidden until the next search or the
  // end of the item decides its last flag.
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |-> state_q == S_IDLE && !ov_q)
    else $error("input taken while busy");
  a_held_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_IDLE |-> held <= HeldW'(MAX_WINDOW))
    else $error("store holds more than the window");
  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_IDLE && in_valid_i && in_ready_o && kind_i |=> vld_q == '0)
    else $error("clear left valid slots");

endmodule

/* bench/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Fragment reorder buffer testbench
// Drives directed and random fragment streams through the reorder buffer,
// predicts every released fragment and status result, and checks each
// result transfer against the prediction under random stalls on both sides.
// ----------------------------------------------------------------------------
module testbench;
  import frbgs_pkg::*;

  localparam int unsigned NumSlots    = 16;
  localparam int unsigned PayBytes    = 8;
  localparam int unsigned MaxReleases = 16;
  localparam int unsigned CycleLimit  = 2000000;
  localparam int unsigned SettleCycles = 1000;

  typedef struct {
    bit          fv;
    bit [63:0]   seq;
    bit [63:0]   pay;
    bit [3:0]    len;
    bit          gap;
    status_e     st;
    bit [63:0]   frags;
    bit [63:0]   gaps;
    bit [63:0]   bytes;
    bit          last;
  } release_t;

  // Tracks the buffer contents and the results still owed by the block.
  class reorder_scoreboard;
    bit [3:0]  window_cfg = 4'd15;
    bit        accept_cfg = 1'b1;
    bit [63:0] next_seq;
    bit        started;
    bit        held[NumSlots];
    bit [63:0] held_seq[NumSlots];
    bit [63:0] held_pay[NumSlots];
    bit [3:0]  held_len[NumSlots];
    bit [63:0] frag_cnt, gap_cnt, byte_cnt;
    release_t  expected_q[$];
    int        errors;

    function int find_slot(bit [63:0] s);
      for (int i = 0; i < NumSlots; i++) begin
        if (held[i] && held_seq[i] == s) return i;
      end
      return -1;
    endfunction

    function int held_total();
      int c;
      c = 0;
      for (int i = 0; i < NumSlots; i++) c += held[i];
      return c;
    endfunction

    function void emit(bit fv, bit [63:0] s, bit [63:0] p, bit [3:0] l, bit g,
                       status_e st);
      release_t r;
      r.fv = fv; r.seq = s; r.pay = p; r.len = l; r.gap = g; r.st = st;
      r.frags = frag_cnt; r.gaps = gap_cnt; r.bytes = byte_cnt; r.last = 1'b0;
      expected_q.push_back(r);
    endfunction

    // Releases the contiguous run that starts at the next expected sequence.
    function void release_run(ref int n, ref bit gap_flag);
      int i;
      i = find_slot(next_seq);
      while (i >= 0) begin
        byte_cnt += held_len[i];
        held[i] = 1'b0;
        if (n < MaxReleases) begin
          emit(1'b1, held_seq[i], held_pay[i], held_len[i], gap_flag, ST_ACCEPTED);
          n++;
        end
        gap_flag = 1'b0;
        next_seq += 64'd1;
        i = find_slot(next_seq);
      end
    endfunction

    function void note_input(bit kind, bit [63:0] s, bit [63:0] p, bit [3:0] l);
      int n;
      int idx;
      bit gap_flag;
      bit have;
      bit [63:0] oldest;
      n = 0;
      gap_flag = 1'b0;
      if (kind) begin
        foreach (held[i]) held[i] = 1'b0;
        next_seq = '0;
        started = 1'b0;
        frag_cnt = '0; gap_cnt = '0; byte_cnt = '0;
        emit(1'b0, '0, '0, '0, 1'b0, ST_CLEARED);
      end else if (!accept_cfg) begin
        emit(1'b0, '0, '0, '0, 1'b0, ST_CLOSED);
      end else begin
        if (!started) begin
          started = 1'b1;
          next_seq = s;
        end
        if (s < next_seq) begin
          emit(1'b0, '0, '0, '0, 1'b0, ST_LATE);
        end else begin
          if (l > PayBytes) l = 4'(PayBytes);
          if (l < 8) p &= (64'd1 << (l * 8)) - 64'd1;
          idx = find_slot(s);
          if (idx < 0) begin
            for (int i = 0; i < NumSlots && idx < 0; i++) begin
              if (!held[i]) idx = i;
            end
          end
          held[idx] = 1'b1;
          held_seq[idx] = s;
          held_pay[idx] = p;
          held_len[idx] = l;
          frag_cnt += 64'd1;
          release_run(n, gap_flag);
          while (held_total() > window_cfg) begin
            have = 1'b0;
            oldest = '0;
            for (int i = 0; i < NumSlots; i++) begin
              if (held[i] && (!have || held_seq[i] < oldest)) begin
                oldest = held_seq[i];
                have = 1'b1;
              end
            end
            gap_cnt += (oldest > next_seq) ? (oldest - next_seq) : 64'd1;
            next_seq = oldest;
            gap_flag = 1'b1;
            release_run(n, gap_flag);
          end
          if (n == 0) emit(1'b0, '0, '0, '0, 1'b0, ST_ACCEPTED);
        end
      end
      expected_q[expected_q.size() - 1].last = 1'b1;
    endfunction

    function void compare(string name, bit [63:0] exp_v, bit [63:0] got_v);
      if (exp_v !== got_v) begin
        errors++;
        if (errors <= 10)
          $display("mismatch on %s: expected %h, got %h", name, exp_v, got_v);
      end
    endfunction

    function void check_result(release_t got);
      release_t want;
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("result transfer with nothing expected");
        return;
      end
      want = expected_q[0];
      expected_q.delete(0);
      compare("fragment_valid", want.fv, got.fv);
      compare("out_seq", want.seq, got.seq);
      compare("out_payload", want.pay, got.pay);
      compare("out_len", want.len, got.len);
      compare("after_gap", want.gap, got.gap);
      compare("status", want.st, got.st);
      compare("fragments_total", want.frags, got.frags);
      compare("gaps_total", want.gaps, got.gaps);
      compare("bytes_total", want.bytes, got.bytes);
      compare("last", want.last, got.last);
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic        kind_i = 1'b0;
  logic [63:0] seq_i = '0;
  logic [63:0] payload_i = '0;
  logic [3:0]  payload_len_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic        fragment_valid_o;
  logic [63:0] out_seq_o, out_payload_o;
  logic [3:0]  out_len_o;
  logic        after_gap_o;
  logic [1:0]  status_o;
  logic [63:0] fragments_total_o, gaps_total_o, bytes_total_o;
  logic        last_o;

  reorder_scoreboard book = new();
  int unsigned cycles;
  bit          hold_request;
  bit          no_stalls;

  fragment_reorder_buffer_gap_skip_top dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Receiver: random stall before each result, plus one long hold-off.
  initial begin
    release_t got;
    int stall;
    @(posedge rst_ni);
    forever begin
      stall = no_stalls ? 0 : $urandom_range(0, 8);
      if (hold_request) begin
        stall = 600;
        hold_request = 1'b0;
      end
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      got.fv = fragment_valid_o; got.seq = out_seq_o; got.pay = out_payload_o;
      got.len = out_len_o; got.gap = after_gap_o; got.st = status_e'(status_o);
      got.frags = fragments_total_o; got.gaps = gaps_total_o;
      got.bytes = bytes_total_o; got.last = last_o;
      book.check_result(got);
    end
  end

  task automatic push(bit kind, bit [63:0] s, bit [63:0] p, bit [3:0] l);
    int gap;
    gap = no_stalls ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    kind_i <= kind;
    seq_i <= s;
    payload_i <= p;
    payload_len_i <= l;
    do @(posedge clk_i); while (!in_ready_o);
    book.note_input(kind, s, p, l);
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (book.expected_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic reg_write(logic [0:0] index, logic [31:0] value);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {index, 2'b00};
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (index == RegWindow) book.window_cfg = value[3:0];
    else book.accept_cfg = value[0];
  endtask

  task automatic configure(bit [3:0] win, bit acc);
    wait_idle();
    reg_write(RegWindow, 32'(win));
    reg_write(RegAccept, 32'(acc));
  endtask

  // Mostly sequences near the expected point, with late, wild and clear items.
  task automatic random_push();
    int pick;
    bit [63:0] s;
    bit [63:0] p;
    bit [3:0] l;
    pick = $urandom_range(0, 99);
    p = {$urandom, $urandom};
    l = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(9, 15)) : 4'($urandom_range(0, 8));
    if (pick < 3) begin
      push(1'b1, {$urandom, $urandom}, p, l);
      return;
    end
    if (!book.started) begin
      s = ($urandom_range(0, 3) == 0) ? 64'hFFFF_FFFF_FFFF_FFF0 + $urandom_range(0, 15)
                                      : {$urandom, $urandom};
    end else if (pick < 10) begin
      s = book.next_seq - $urandom_range(1, 6);
    end else if (pick < 14) begin
      s = {$urandom, $urandom};
    end else begin
      s = book.next_seq + $urandom_range(0, book.window_cfg + 3);
    end
    push(1'b0, s, p, l);
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: in-order, reorder, late, duplicate, length trimming, wrap.
    push(1'b0, 64'd100, '1, 4'd8);
    push(1'b0, 64'd102, 64'h0123_4567_89AB_CDEF, 4'd4);
    push(1'b0, 64'd103, 64'hFEDC_BA98_7654_3210, 4'd1);
    push(1'b0, 64'd101, 64'hAAAA_5555_AAAA_5555, 4'd7);
    push(1'b0, 64'd99, '1, 4'd8);
    push(1'b0, 64'd105, '1, 4'd15);
    push(1'b0, 64'd105, 64'h1122_3344_5566_7788, 4'd3);
    push(1'b0, 64'd104, '1, 4'd9);
    push(1'b0, 64'd106, '1, 4'd0);
    push(1'b0, '1, 64'h5555_AAAA_5555_AAAA, 4'd2);
    push(1'b1, '1, '1, 4'd15);
    push(1'b0, '1, '1, 4'd8);
    push(1'b0, 64'd0, 64'h8000_0000_0000_0001, 4'd8);
    push(1'b0, 64'h5555_5555_5555_5555, '0, 4'd6);
    push(1'b1, '0, '0, 4'd0);
    push(1'b0, 64'd0, '0, 4'd5);
    push(1'b0, 64'd1, '1, 4'd8);

    // Window of one with a held fragment forces gap concessions.
    configure(4'd1, 1'b1);
    push(1'b0, 64'd5, '1, 4'd8);
    push(1'b0, 64'd9, '1, 4'd8);
    push(1'b0, 64'd3, '1, 4'd8);

    configure(4'd0, 1'b1);
    repeat (40) random_push();

    configure(4'd4, 1'b1);
    no_stalls = 1'b1;
    repeat (30) random_push();
    no_stalls = 1'b0;

    configure(4'd15, 1'b0);
    repeat (12) random_push();

    // Long receiver hold-off while many in-window fragments are offered.
    configure(4'd15, 1'b1);
    hold_request = 1'b1;
    repeat (50) random_push();

    configure(4'd9, 1'b1);
    repeat (40) random_push();

    configure(4'd1, 1'b1);
    repeat (30) random_push();

    configure(4'($urandom_range(2, 14)), 1'b1);
    repeat (40) random_push();

    wait_idle();
    if (book.errors == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end
endmodule
